[design/bce_pkg.sv]
// Shared types, constants and helpers for the binomial coefficient engine.
// Holds the request and response word types and the saturating adder.
// No dependencies.
`default_nettype none

package bce_pkg;

    // Largest total count the scratch row can hold.
    localparam int MAX_N      = 63;
    localparam int ROW_DEPTH  = MAX_N + 1;
    localparam int ROW_ADDR_W = $clog2(ROW_DEPTH);
    localparam int COUNT_W    = 6;
    localparam int COEF_W     = 31;
    localparam int STATUS_W   = 2;

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1);

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] choose_count;
    } bce_req_t;

    typedef struct packed {
        logic [COEF_W-1:0]   coefficient;
        logic [STATUS_W-1:0] status;
    } bce_rsp_t;

    // Add two coefficients, clamping at the largest representable value.
    function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                  input logic [COEF_W-1:0] b);
        logic [COEF_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COEF_W] ? COEF_MAX : sum[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/binomial_coefficient_engine_core.sv]
// Binomial coefficient engine: C(n,m) by Pascal's rule over a scratch row RAM.
// Each row i is built by a prime step (diagonal entry and first read), a fetch step
// when any column is to be summed, then one add step per column from min(i-1,m) down
// to 1. A choose count above total goes straight to the result. One request at a time,
// paced by the single adder and read port.
// Reset (aresetn, synchronous): sequencer and output valid cleared; RAM not.
`default_nettype none

module binomial_coefficient_engine_core
    import bce_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bce_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output bce_rsp_t      m_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_PRIME = 7'b0000100,
        ST_FETCH = 7'b0001000,
        ST_ADD   = 7'b0010000,
        ST_RDRES = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] m_reg, m_next;
    logic [COUNT_W-1:0] i_reg, i_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [COEF_W-1:0]  hi_reg, hi_next;
    logic               bad_reg, bad_next;
    logic               m_valid_reg, m_valid_next;
    bce_rsp_t           m_data_reg, m_data_next;

    logic                  wr_en;
    logic [ROW_ADDR_W-1:0] wr_addr;
    logic [COEF_W-1:0]     wr_data;
    logic [ROW_ADDR_W-1:0] rd_addr;
    logic [COEF_W-1:0]     rd_data;

    logic               i_le_m;
    logic [COUNT_W-1:0] k_first;
    logic               out_free;

    // Scratch row of Pascal's triangle
    bce_ram #(
        .WIDTH(COEF_W),
        .DEPTH(ROW_DEPTH)
    ) u_row_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // First column to sum on row i; column i itself is set to one when in range
    assign i_le_m  = (i_reg <= m_reg);
    assign k_first = i_le_m ? (i_reg - COUNT_W'(1)) : m_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        hi_next      = hi_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = ROW_ADDR_W'(k_reg);
        wr_data      = sat_add(hi_reg, rd_data);
        rd_addr      = ROW_ADDR_W'(m_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next   = s_data.total_count;
                    m_next   = s_data.choose_count;
                    bad_next = (s_data.choose_count > s_data.total_count);
                    state_next = (s_data.choose_count > s_data.total_count)
                                 ? ST_EMIT : ST_INIT;
                end
            end
            ST_INIT: begin
                // row 0
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = COEF_ONE;
                i_next  = COUNT_W'(1);
                state_next = (n_reg == '0) ? ST_RDRES : ST_PRIME;
            end
            ST_PRIME: begin
                // diagonal entry of this row, and first read
                wr_en   = i_le_m;
                wr_addr = ROW_ADDR_W'(i_reg);
                wr_data = COEF_ONE;
                rd_addr = ROW_ADDR_W'(k_first);
                k_next  = k_first;
                if (k_first != '0) begin
                    state_next = ST_FETCH;
                end else if (i_reg == n_reg) begin
                    state_next = ST_RDRES;
                end else begin
                    i_next = i_reg + COUNT_W'(1);
                end
            end
            ST_FETCH: begin
                hi_next    = rd_data;
                rd_addr    = ROW_ADDR_W'(k_reg - COUNT_W'(1));
                state_next = ST_ADD;
            end
            ST_ADD: begin
                // row[k] = row[k] + row[k-1]; row[k-1] carried to next column
                wr_en   = 1'b1;
                hi_next = rd_data;
                rd_addr = ROW_ADDR_W'(k_reg - COUNT_W'(2));
                k_next  = k_reg - COUNT_W'(1);
                if (k_reg == COUNT_W'(1)) begin
                    if (i_reg == n_reg) begin
                        state_next = ST_RDRES;
                    end else begin
                        i_next     = i_reg + COUNT_W'(1);
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_RDRES: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // rd_data holds row[m] while waiting for the output slot
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bad_reg) begin
                        m_data_next.coefficient = '0;
                        m_data_next.status      = STATUS_INVALID;
                    end else begin
                        m_data_next.coefficient = rd_data;
                        m_data_next.status      = (rd_data == COEF_MAX)
                                                  ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        m_reg      <= m_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        hi_reg     <= hi_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

[design/bce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bce_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/bce_checker.sv]
// Port-level checker for the binomial coefficient engine, bound to the top level.
// Depends on bce_pkg and binomial_coefficient_engine_core.
`default_nettype none

module bce_checker
    import bce_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire bce_req_t s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire bce_rsp_t m_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // Invalid requests carry a zero coefficient
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_INVALID |-> m_data.coefficient == '0)
        else $error("invalid result with nonzero coefficient");

    // Overflow status goes with a saturated coefficient, and only then
    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_INVALID |->
            ((m_data.status == STATUS_OVERFLOW) == (m_data.coefficient == COEF_MAX)))
        else $error("overflow status disagrees with coefficient");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_OK || m_data.status == STATUS_OVERFLOW
                    || m_data.status == STATUS_INVALID)
        else $error("undefined status code");

endmodule

bind binomial_coefficient_engine_core bce_checker u_bce_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
